// ===== rtl/core/mae_pkg.sv =====
// Shared types, constants and helper functions of the matrix arithmetic engine.
package mae_pkg;

  // Storage shape and element width.
  localparam int MAX_DIM    = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);
  localparam int CNT_W      = $clog2(MAX_DIM + 1);

  // Fixed field widths of the interface.
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int REG_W    = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_TRN_A = 3'd3,
    OP_TRN_B = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_WRITE_A = 2'd0,
    MODE_WRITE_B = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPERATION = 3'd0,
    CFG_ROWS_A    = 3'd1,
    CFG_COLS_A    = 3'd2,
    CFG_ROWS_B    = 3'd3,
    CFG_COLS_B    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SINGLE,
    ST_MAC,
    ST_DONE
  } state_t;

  // One input request.
  typedef struct packed {
    logic [1:0]               mode;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  // One result.
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [1:0]                status;
  } out_t;

  // A shape register above MAX_DIM behaves as MAX_DIM.
  function automatic logic [CNT_W-1:0] eff_dim(input logic [REG_W-1:0] r);
    logic [CNT_W-1:0] d;
    if (int'(r) > MAX_DIM) d = CNT_W'(MAX_DIM);
    else                   d = CNT_W'(r);
    return d;
  endfunction

  // Flat store address of a row and column.
  function automatic logic [ADDR_W-1:0] addr_of(input int r, input int c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

  // Input value to element width, sign-extended or truncated.
  function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic [VALUE_W-1:0] v);
    logic [ELEM_WIDTH-1:0] e;
    for (int i = 0; i < ELEM_WIDTH; i++) begin
      e[i] = v[(i < VALUE_W) ? i : VALUE_W-1];
    end
    return e;
  endfunction

  // Element to output width, sign-extended or truncated.
  function automatic logic [VALUE_W-1:0] to_value(input logic [ELEM_WIDTH-1:0] e);
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < VALUE_W; i++) begin
      v[i] = e[(i < ELEM_WIDTH) ? i : ELEM_WIDTH-1];
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/mae_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/matrix_arithmetic_engine_unit.sv =====
// Top level of the matrix arithmetic engine: element stores, control sequencer and MAC.
//
//   channel   direction  handshake          payload
//   in        request    in_valid/in_stall   mode, row, col, value
//   out       result     out_valid/out_stall result_value, status
//   cfg       write      cfg_write           cfg_index, cfg_data
//
// A write request gives no result. A read of add, subtract or transpose passes through
// the fetch, single and done states to the result register; a multiply read makes one
// multiply-accumulate per cycle through the store read ports. A read that ends in an
// error status goes straight to the done state. Reset is synchronous and needs no
// clearing pass; the user must have entries read only once written, as the block
// itself does not enforce this. A waiting result stalls the sequencer only at its
// final step, and a write request can still be accepted while a result waits.
module matrix_arithmetic_engine_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mae_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mae_pkg::out_t                out_data,
  input  logic                         cfg_write,
  input  logic [mae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mae_pkg::REG_W-1:0]    cfg_data
);
  import mae_pkg::*;

  // Configuration registers.
  logic [2:0]       operation;
  logic [REG_W-1:0] rows_a, cols_a, rows_b, cols_b;

  // Sequencer state and per-request registers.
  state_t           state, state_next;
  logic [2:0]       op_lat;
  logic [POS_W-1:0] row_lat, col_lat;
  logic [1:0]       status_lat;
  logic [CNT_W-1:0] mac_len, k;
  logic             rd_vld, prod_vld;
  logic [ELEM_WIDTH-1:0] prod, acc;

  // Store ports.
  logic                  a_we, b_we;
  logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] wdata, a_rdata, b_rdata;
  logic [2*ELEM_WIDTH-1:0] prod_full;

  // Decoded control.
  logic accept, issuing, load_out, ok_shape, in_range;
  logic [CNT_W-1:0] ra, ca, rb, cb, rr, rc;
  logic [1:0] status_new;

  assign accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_ADD;
      rows_a    <= REG_W'(1);
      cols_a    <= REG_W'(1);
      rows_b    <= REG_W'(1);
      cols_b    <= REG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OPERATION: operation <= cfg_data[2:0];
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_COLS_A:    cols_a    <= cfg_data;
        CFG_ROWS_B:    rows_b    <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Result shape and status of a read request.
  always_comb begin
    ra = eff_dim(rows_a);
    ca = eff_dim(cols_a);
    rb = eff_dim(rows_b);
    cb = eff_dim(cols_b);
    ok_shape = 1'b1;
    rr = '0;
    rc = '0;
    case (operation)
      OP_ADD, OP_SUB: begin
        ok_shape = (ra == rb) && (ca == cb);
        rr = ra;
        rc = ca;
      end
      OP_MUL: begin
        ok_shape = (ca == rb);
        rr = ra;
        rc = cb;
      end
      OP_TRN_A: begin
        rr = ca;
        rc = ra;
      end
      OP_TRN_B: begin
        rr = cb;
        rc = rb;
      end
      default: ok_shape = 1'b0;
    endcase
    if (!ok_shape) begin
      status_new = STATUS_MISMATCH;
    end else if (int'(in_data.row) >= int'(rr) || int'(in_data.col) >= int'(rc)) begin
      status_new = STATUS_RANGE;
    end else begin
      status_new = STATUS_OK;
    end
  end

  // Element writes go straight to the stores; reads come only in later cycles,
  // so a read never overlaps a write to the same entry.
  assign in_range = (int'(in_data.row) < MAX_DIM) && (int'(in_data.col) < MAX_DIM);
  assign waddr = addr_of(int'(in_data.row), int'(in_data.col));
  assign wdata = to_elem(in_data.value);
  assign a_we  = accept && in_range && (in_data.mode == MODE_WRITE_A);
  assign b_we  = accept && in_range && (in_data.mode == MODE_WRITE_B);

  // Read addresses: walk row of A and column of B for multiply, else one position.
  always_comb begin
    if (state == ST_MAC) begin
      a_raddr = addr_of(int'(row_lat), int'(k));
      b_raddr = addr_of(int'(k), int'(col_lat));
    end else if (op_lat == OP_TRN_A || op_lat == OP_TRN_B) begin
      a_raddr = addr_of(int'(col_lat), int'(row_lat));
      b_raddr = addr_of(int'(col_lat), int'(row_lat));
    end else begin
      a_raddr = addr_of(int'(row_lat), int'(col_lat));
      b_raddr = addr_of(int'(row_lat), int'(col_lat));
    end
  end

  mae_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mae_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_data.mode == MODE_READ) begin
          if (status_new != STATUS_OK)  state_next = ST_DONE;
          else if (operation == OP_MUL) state_next = ST_MAC;
          else                          state_next = ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_SINGLE;
      ST_SINGLE: state_next = ST_DONE;
      ST_MAC: begin
        if (!issuing && !rd_vld && !prod_vld) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall = 1'b1;
    issuing  = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_MAC:  issuing  = (k != mac_len);
      ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issuing;
      prod_vld <= rd_vld;
    end
  end

  // Request registers, multiply pipeline and accumulator.
  assign prod_full = a_rdata * b_rdata;

  always_ff @(posedge clk) begin
    if (accept && in_data.mode == MODE_READ) begin
      op_lat     <= operation;
      row_lat    <= in_data.row;
      col_lat    <= in_data.col;
      status_lat <= status_new;
      mac_len    <= ca;
      k          <= '0;
      acc        <= '0;
    end else begin
      if (issuing) begin
        k <= k + CNT_W'(1);
      end
      if (state == ST_SINGLE) begin
        case (op_lat)
          OP_ADD:   acc <= a_rdata + b_rdata;
          OP_SUB:   acc <= a_rdata - b_rdata;
          OP_TRN_A: acc <= a_rdata;
          default:  acc <= b_rdata;
        endcase
      end else if (prod_vld) begin
        acc <= acc + prod;
      end
    end
    prod <= prod_full[ELEM_WIDTH-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.result_value <= to_value(acc);
      out_data.status       <= status_lat;
    end
  end

endmodule

// ===== rtl/core/mae_checker.sv =====
// Port-level checker for the matrix arithmetic engine, bound to the top level.
module mae_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input mae_pkg::in_t                  in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input mae_pkg::out_t                 out_data,
  input logic                          cfg_write,
  input logic [mae_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [mae_pkg::REG_W-1:0]     cfg_data
);
  import mae_pkg::*;

  logic accept;
  logic cfg_seen;

  assign accept = in_valid && !in_stall;
  assign cfg_seen = cfg_write && (cfg_index == CFG_OPERATION) && (cfg_data == '0);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |-> out_data.result_value == '0)
    else $error("error result with non-zero value");

  // A write request never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode != MODE_READ && !out_valid && !cfg_seen |=> !out_valid)
    else $error("result appeared after a write request");

  // A read request keeps the block busy in the following cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == MODE_READ |=> in_stall)
    else $error("request accepted while a read was in progress");

endmodule

bind matrix_arithmetic_engine_unit mae_checker u_mae_checker (.*);
